[rtl/lgs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared sizes, count types, operation codes and sequencer states of the
// topic-model token sampler.
// ----------------------------------------------------------------------------
package lgs_pkg;

   localparam int NUM_TOPICS = 16;
   localparam int VOCAB_SIZE = 4096;
   localparam int NUM_DOCS   = 1024;
   localparam int NUM_TOKENS = 65536;

   localparam int TOPIC_W = $clog2(NUM_TOPICS);
   localparam int WORD_W  = $clog2(VOCAB_SIZE);
   localparam int DOC_W   = $clog2(NUM_DOCS);
   localparam int TOKEN_W = $clog2(NUM_TOKENS);
   localparam int CNT_W   = 17;
   localparam int SUM_W   = 48;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef logic [CNT_W-1:0] cnt_type;
   typedef cnt_type [NUM_TOPICS-1:0] row_type;

   typedef enum logic [1:0] {
      OP_CLEAR    = 2'd0,
      OP_ASSIGN   = 2'd1,
      OP_RESAMPLE = 2'd2
   } op_type;

   localparam logic [1:0] CSR_ALPHA  = 2'd0;
   localparam logic [1:0] CSR_BETA   = 2'd1;
   localparam logic [1:0] CSR_SMOOTH = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_WSET,
      S_DIV,
      S_MUL,
      S_ACC,
      S_TGT1,
      S_TGT2,
      S_SRCH,
      S_WRITE,
      S_RESP
   } state_type;

   // Saturating count steps.
   function automatic cnt_type cnt_inc(input cnt_type c);
      return (c == CNT_MAX) ? c : cnt_type'(c + 1'b1);
   endfunction

   function automatic cnt_type cnt_dec(input cnt_type c);
      return (c == '0) ? c : cnt_type'(c - 1'b1);
   endfunction

endpackage
`default_nettype wire

[rtl/lda_collapsed_gibbs_token_sampler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lda_collapsed_gibbs_token_sampler
// Collapsed Gibbs sampler for a topic model: one word token per request beat.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_ready  operation, doc_index, word_id,
//                                           token_index, initial_topic, uniform
//  rsp_     out        rsp_valid/rsp_ready  topic
//  csr_     in         csr_valid/csr_ready  index, data (alpha, beta, smoothing)
//
//  One request at a time. Assign goes from the load step to the write-back,
//  which loads the response register. Resample runs, per topic, a radix-2
//  divider (skipped if the denominator is zero or the ratio saturates), one
//  multiply and one accumulate, then the target product and a search over up
//  to 16 topics. Clear sweeps the count memories one row a cycle. The same
//  sweep runs after reset, and no request beat is taken until it ends. A
//  finished result waits in the response register; the next request beat is
//  taken meanwhile; only the final write-back or response step stalls on it.
//
module lda_collapsed_gibbs_token_sampler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [9:0]  req_doc_index,
   input  wire logic [11:0] req_word_id,
   input  wire logic [15:0] req_token_index,
   input  wire logic [3:0]  req_initial_topic,
   input  wire logic [31:0] req_uniform,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_topic,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int NT      = lgs_pkg::NUM_TOPICS;
   localparam int TW      = lgs_pkg::TOPIC_W;
   localparam int SW      = lgs_pkg::SUM_W;
   localparam logic [TW-1:0] LAST_TOPIC = TW'(NT - 1);
   localparam logic [lgs_pkg::WORD_W-1:0] LAST_ROW = lgs_pkg::WORD_W'(lgs_pkg::VOCAB_SIZE - 1);

   // Count memories, one row of all topic counts per entry, and the topic of each token.
   lgs_pkg::row_type word_mem [lgs_pkg::VOCAB_SIZE];
   lgs_pkg::row_type doc_mem  [lgs_pkg::NUM_DOCS];
   logic [TW-1:0]    tok_mem  [lgs_pkg::NUM_TOKENS];

   lgs_pkg::row_type word_rd_ff, doc_rd_ff;
   logic [TW-1:0]    tok_rd_ff;

   lgs_pkg::state_type state_ff, state_in;

   // Configuration.
   logic [23:0] alpha_ff, beta_ff;
   logic [31:0] smooth_ff;

   // Captured request.
   logic [1:0]                    op_ff;
   logic [lgs_pkg::DOC_W-1:0]     doc_ff;
   logic [lgs_pkg::WORD_W-1:0]    word_ff;
   logic [lgs_pkg::TOKEN_W-1:0]   token_ff;
   logic [31:0]                   uni_ff;

   // Working rows and topic totals.
   lgs_pkg::row_type wrow_ff, drow_ff;
   lgs_pkg::cnt_type total_ff [NT];

   logic [TW-1:0] k_ff, chosen_ff;
   logic [lgs_pkg::WORD_W-1:0] clr_ff;
   logic          rst_pass_ff;

   // Divider and accumulator.
   logic [33:0]   den_ff, rem_ff;
   logic [31:0]   dvd_ff, quo_ff;
   logic [4:0]    div_cnt_ff;
   logic [63:0]   prod_ff, plo_ff;
   logic [SW-1:0] sum_ff;
   logic [SW-1:0] cw_ff [NT];
   logic [SW:0]   target_ff;

   logic          rsp_valid_ff;
   logic [TW-1:0] rsp_topic_ff;

   logic accept, out_free, is_resample;
   logic word_we, doc_we, tok_we, load_rsp;
   logic [33:0] num_w, den_w, dterm_w;
   logic        den_zero, ratio_sat, hit;
   logic [34:0] trial, diff;
   logic        trial_ge;
   logic [SW:0] sum_add;
   lgs_pkg::row_type wrow_dec, drow_dec, wrow_inc, drow_inc;
   lgs_pkg::row_type word_wdata, doc_wdata;
   logic [lgs_pkg::WORD_W-1:0] word_waddr;
   logic [lgs_pkg::DOC_W-1:0]  doc_waddr;

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_topic   = rsp_topic_ff;
   assign accept      = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign is_resample = (op_ff == lgs_pkg::OP_RESAMPLE);

   // ---------------------------------------------------------------- datapath
   always_comb begin
      // Weight terms of topic k in Q18.16.
      num_w   = {1'b0, wrow_ff[k_ff], 16'h0} + 34'(beta_ff);
      den_w   = {1'b0, total_ff[k_ff], 16'h0} + 34'(smooth_ff);
      dterm_w = {1'b0, drow_ff[k_ff], 16'h0} + 34'(alpha_ff);
      den_zero  = (den_w == '0);
      // Quotient reaches 2^32 when num >= den * 2^16.
      ratio_sat = {16'h0, num_w} >= {den_w, 16'h0};
      // One restoring step: shift in the next dividend bit.
      trial    = {rem_ff, dvd_ff[31]};
      diff     = trial - {1'b0, den_ff};
      trial_ge = trial >= {1'b0, den_ff};
      sum_add  = {1'b0, sum_ff} + {1'b0, prod_ff[63:16]};
      hit      = ({1'b0, cw_ff[k_ff]} > target_ff);
   end

   // Drop the old topic from the rows on a resample, add the chosen one later.
   always_comb begin
      wrow_dec = word_rd_ff;
      drow_dec = doc_rd_ff;
      if (is_resample) begin
         wrow_dec[tok_rd_ff] = lgs_pkg::cnt_dec(word_rd_ff[tok_rd_ff]);
         drow_dec[tok_rd_ff] = lgs_pkg::cnt_dec(doc_rd_ff[tok_rd_ff]);
      end
      wrow_inc = wrow_ff;
      drow_inc = drow_ff;
      wrow_inc[chosen_ff] = lgs_pkg::cnt_inc(wrow_ff[chosen_ff]);
      drow_inc[chosen_ff] = lgs_pkg::cnt_inc(drow_ff[chosen_ff]);
   end

   always_comb begin
      if (state_ff == lgs_pkg::S_CLEAR) begin
         word_waddr = clr_ff;
         doc_waddr  = clr_ff[lgs_pkg::DOC_W-1:0];
         word_wdata = '0;
         doc_wdata  = '0;
      end else begin
         word_waddr = word_ff;
         doc_waddr  = doc_ff;
         word_wdata = wrow_inc;
         doc_wdata  = drow_inc;
      end
   end

   // ------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lgs_pkg::S_CLEAR: begin
            if (clr_ff == LAST_ROW) state_in = rst_pass_ff ? lgs_pkg::S_IDLE : lgs_pkg::S_RESP;
         end
         lgs_pkg::S_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  lgs_pkg::OP_CLEAR:    state_in = lgs_pkg::S_CLEAR;
                  lgs_pkg::OP_ASSIGN,
                  lgs_pkg::OP_RESAMPLE: state_in = lgs_pkg::S_LOAD;
                  default:              state_in = lgs_pkg::S_RESP;
               endcase
            end
         end
         lgs_pkg::S_LOAD: state_in = is_resample ? lgs_pkg::S_WSET : lgs_pkg::S_WRITE;
         lgs_pkg::S_WSET: state_in = (den_zero || ratio_sat) ? lgs_pkg::S_MUL : lgs_pkg::S_DIV;
         lgs_pkg::S_DIV:  begin
            if (div_cnt_ff == 5'd31) state_in = lgs_pkg::S_MUL;
         end
         lgs_pkg::S_MUL:  state_in = lgs_pkg::S_ACC;
         lgs_pkg::S_ACC:  state_in = (k_ff == LAST_TOPIC) ? lgs_pkg::S_TGT1 : lgs_pkg::S_WSET;
         lgs_pkg::S_TGT1: state_in = lgs_pkg::S_TGT2;
         lgs_pkg::S_TGT2: state_in = lgs_pkg::S_SRCH;
         lgs_pkg::S_SRCH: begin
            if (hit || k_ff == LAST_TOPIC) state_in = lgs_pkg::S_WRITE;
         end
         lgs_pkg::S_WRITE,
         lgs_pkg::S_RESP: begin
            if (out_free) state_in = lgs_pkg::S_IDLE;
         end
         default: state_in = lgs_pkg::S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_ready = 1'b0;
      word_we   = 1'b0;
      doc_we    = 1'b0;
      tok_we    = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         lgs_pkg::S_IDLE:  req_ready = 1'b1;
         lgs_pkg::S_CLEAR: begin
            word_we = 1'b1;
            doc_we  = (clr_ff < lgs_pkg::WORD_W'(lgs_pkg::NUM_DOCS));
         end
         lgs_pkg::S_WRITE: begin
            word_we  = out_free;
            doc_we   = out_free;
            tok_we   = out_free;
            load_rsp = out_free;
         end
         lgs_pkg::S_RESP:  load_rsp = out_free;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (accept) begin
         word_rd_ff <= word_mem[req_word_id];
         doc_rd_ff  <= doc_mem[req_doc_index];
         tok_rd_ff  <= tok_mem[req_token_index];
      end
      if (word_we) word_mem[word_waddr] <= word_wdata;
      if (doc_we)  doc_mem[doc_waddr]   <= doc_wdata;
      if (tok_we)  tok_mem[token_ff]    <= chosen_ff;
   end

   // ----------------------------------------------------------- control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgs_pkg::S_CLEAR;
         rst_pass_ff  <= 1'b1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         alpha_ff     <= 24'h010000;
         beta_ff      <= 24'h010000;
         smooth_ff    <= 32'h00010000;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               lgs_pkg::CSR_ALPHA:  alpha_ff  <= csr_data[23:0];
               lgs_pkg::CSR_BETA:   beta_ff   <= csr_data[23:0];
               lgs_pkg::CSR_SMOOTH: smooth_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == lgs_pkg::S_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == LAST_ROW) rst_pass_ff <= 1'b0;
         end
         if (load_rsp)      rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // --------------------------------------------------------- working values
   always_ff @(posedge clock) begin
      if (load_rsp) rsp_topic_ff <= chosen_ff;
      unique case (state_ff)
         lgs_pkg::S_CLEAR: begin
            for (int i = 0; i < NT; i++) total_ff[i] <= '0;
            chosen_ff <= '0;
         end
         lgs_pkg::S_IDLE: begin
            if (accept) begin
               op_ff     <= req_operation;
               doc_ff    <= req_doc_index;
               word_ff   <= req_word_id;
               token_ff  <= req_token_index;
               uni_ff    <= req_uniform;
               chosen_ff <= (req_operation == lgs_pkg::OP_ASSIGN) ? req_initial_topic : '0;
            end
         end
         lgs_pkg::S_LOAD: begin
            wrow_ff <= wrow_dec;
            drow_ff <= drow_dec;
            if (is_resample) total_ff[tok_rd_ff] <= lgs_pkg::cnt_dec(total_ff[tok_rd_ff]);
            k_ff   <= '0;
            sum_ff <= '0;
         end
         lgs_pkg::S_WSET: begin
            den_ff     <= den_w;
            rem_ff     <= {16'h0, num_w[33:16]};
            dvd_ff     <= {num_w[15:0], 16'h0};
            div_cnt_ff <= '0;
            quo_ff     <= (den_zero && num_w == '0) ? 32'h0 : 32'hFFFF_FFFF;
         end
         lgs_pkg::S_DIV: begin
            rem_ff     <= trial_ge ? diff[33:0] : trial[33:0];
            quo_ff     <= {quo_ff[30:0], trial_ge};
            dvd_ff     <= {dvd_ff[30:0], 1'b0};
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         lgs_pkg::S_MUL: begin
            prod_ff <= quo_ff * ((dterm_w[33:32] != 2'b00) ? 32'hFFFF_FFFF : dterm_w[31:0]);
         end
         lgs_pkg::S_ACC: begin
            // Saturate the running sum at 48 bits.
            sum_ff       <= sum_add[SW] ? '1 : sum_add[SW-1:0];
            cw_ff[k_ff]  <= sum_add[SW] ? '1 : sum_add[SW-1:0];
            k_ff         <= k_ff + 1'b1;
         end
         lgs_pkg::S_TGT1: plo_ff <= uni_ff * sum_ff[31:0];
         lgs_pkg::S_TGT2: begin
            target_ff <= (SW+1)'(uni_ff * sum_ff[SW-1:32]) + (SW+1)'(plo_ff[63:32]);
            k_ff      <= '0;
         end
         lgs_pkg::S_SRCH: begin
            chosen_ff <= k_ff;
            k_ff      <= k_ff + 1'b1;
         end
         lgs_pkg::S_WRITE: begin
            if (out_free && op_ff != lgs_pkg::OP_CLEAR) begin
               total_ff[chosen_ff] <= lgs_pkg::cnt_inc(total_ff[chosen_ff]);
            end
         end
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   // A taken request beat always starts work.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != lgs_pkg::S_IDLE))
      else $error("request beat taken but sequencer stayed idle");

   // Restoring division keeps the partial remainder below the divisor.
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lgs_pkg::S_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder out of range");

   // A search hit goes straight to write-back.
   a_hit_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lgs_pkg::S_SRCH && hit) |=> (state_ff == lgs_pkg::S_WRITE))
      else $error("search hit did not end the search");

   // A response is loaded only when the slot is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending response overwritten");
`endif

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the topic-model token sampler: a queue-fed driver
// and a monitor check every response beat against an in-bench prediction of
// the count memories, the token topics and the Q16.16 weight search.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int N_RANDOM = 2000;
   localparam int NT = lgs_pkg::NUM_TOPICS;

   typedef struct {
      logic [1:0]  op;
      logic [9:0]  doc;
      logic [11:0] word;
      logic [15:0] token;
      logic [3:0]  init;
      logic [31:0] uni;
   } token_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0]  req_operation = '0;
   logic [9:0]  req_doc_index = '0;
   logic [11:0] req_word_id = '0;
   logic [15:0] req_token_index = '0;
   logic [3:0]  req_initial_topic = '0;
   logic [31:0] req_uniform = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [3:0] rsp_topic;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   lda_collapsed_gibbs_token_sampler dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the block's state and registers.
   logic [23:0] sh_alpha = 24'd65536, sh_beta = 24'd65536;
   logic [31:0] sh_smooth = 32'd65536;
   logic [16:0] word_cnt [0:lgs_pkg::VOCAB_SIZE*NT-1];
   logic [16:0] doc_cnt [0:lgs_pkg::NUM_DOCS*NT-1];
   logic [16:0] total_cnt [0:NT-1];
   logic [3:0]  token_topic [0:lgs_pkg::NUM_TOKENS-1];
   bit          token_set [0:lgs_pkg::NUM_TOKENS-1];

   token_beat_type pending_beats[$];
   logic [3:0]  expected_topics[$];
   token_beat_type cur_beat;
   int sent = 0, received = 0, mismatches = 0, n_clear = 0, n_resample = 0;
   int idle_pct = 37;
   int stall_left = 0;
   bit long_stall_done = 0;

   function automatic void clear_counts();
      foreach (word_cnt[i]) word_cnt[i] = '0;
      foreach (doc_cnt[i]) doc_cnt[i] = '0;
      foreach (total_cnt[i]) total_cnt[i] = '0;
   endfunction

   function automatic logic [16:0] sat_up(logic [16:0] c);
      return (c == 17'h1FFFF) ? c : c + 17'd1;
   endfunction

   function automatic logic [16:0] sat_down(logic [16:0] c);
      return (c == 17'd0) ? c : c - 17'd1;
   endfunction

   function automatic logic [47:0] topic_weight(logic [16:0] wc, logic [16:0] tc,
                                                logic [16:0] dc);
      logic [63:0] num, den, ratio, dterm, prod;
      num = ({47'd0, wc} << 16) + sh_beta;
      den = ({47'd0, tc} << 16) + sh_smooth;
      if (den == 0) ratio = (num != 0) ? 64'hFFFF_FFFF : 64'd0;
      else begin
         ratio = (num << 16) / den;
         if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
      end
      dterm = ({47'd0, dc} << 16) + sh_alpha;
      if (dterm > 64'hFFFF_FFFF) dterm = 64'hFFFF_FFFF;
      prod = ratio * dterm;
      return prod[63:16];
   endfunction

   // Work out the topic a beat leaves the token with, updating the shadow state.
   function automatic logic [3:0] sample_topic(token_beat_type b);
      int wb, db, old;
      logic [63:0] running, target, u;
      logic [47:0] cum [0:NT-1];
      logic [3:0] k;
      wb = int'(b.word) * NT;
      db = int'(b.doc) * NT;
      k = '0;
      if (b.op == lgs_pkg::OP_CLEAR) clear_counts();
      else if (b.op == lgs_pkg::OP_ASSIGN || b.op == lgs_pkg::OP_RESAMPLE) begin
         if (b.op == lgs_pkg::OP_ASSIGN) k = b.init;
         else begin
            old = token_topic[b.token];
            doc_cnt[db+old] = sat_down(doc_cnt[db+old]);
            total_cnt[old] = sat_down(total_cnt[old]);
            word_cnt[wb+old] = sat_down(word_cnt[wb+old]);
            running = 0;
            for (int i = 0; i < NT; i++) begin
               running += {16'd0, topic_weight(word_cnt[wb+i], total_cnt[i], doc_cnt[db+i])};
               if (running > 64'hFFFF_FFFF_FFFF) running = 64'hFFFF_FFFF_FFFF;
               cum[i] = running[47:0];
            end
            u = {32'd0, b.uni};
            target = u * (running >> 32) + ((u * (running & 64'hFFFF_FFFF)) >> 32);
            k = 4'(NT - 1);
            for (int i = NT - 1; i >= 0; i--)
               if ({16'd0, cum[i]} > target) k = i[3:0];
         end
         token_topic[b.token] = k;
         doc_cnt[db+k] = sat_up(doc_cnt[db+k]);
         total_cnt[k] = sat_up(total_cnt[k]);
         word_cnt[wb+k] = sat_up(word_cnt[wb+k]);
      end
      return k;
   endfunction

   // Driver: predict on acceptance, then offer the next queued beat or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_topics.push_back(sample_topic(cur_beat));
            sent++;
            idle_pct <= (sent >= 1300 && sent < 1700) ? 0 : 37;
         end
         if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
            cur_beat = pending_beats.pop_front();
            req_valid         <= 1'b1;
            req_operation     <= cur_beat.op;
            req_doc_index     <= cur_beat.doc;
            req_word_id       <= cur_beat.word;
            req_token_index   <= cur_beat.token;
            req_initial_topic <= cur_beat.init;
            req_uniform       <= cur_beat.uni;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each response beat, then choose the next ready level.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            received++;
            if (expected_topics.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response beat: topic %0d", rsp_topic);
            end else begin
               logic [3:0] want;
               want = expected_topics.pop_front();
               if (rsp_topic !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("topic mismatch at response %0d: expected %0d, got %0d",
                              received, want, rsp_topic);
               end
            end
         end
         // Hold off once for a long stretch so the block backs up its input.
         if (!long_stall_done && sent >= 1000) begin
            long_stall_done <= 1'b1;
            stall_left <= 3000;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // Check on the falling edge, once every update of the rising edge has settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_topics.size() != 0);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         lgs_pkg::CSR_ALPHA:  sh_alpha = val[23:0];
         lgs_pkg::CSR_BETA:   sh_beta = val[23:0];
         lgs_pkg::CSR_SMOOTH: sh_smooth = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic queue_beat(logic [1:0] op, logic [9:0] doc, logic [11:0] word,
                             logic [15:0] token, logic [3:0] init, logic [31:0] uni);
      token_beat_type b;
      b = '{op, doc, word, token, init, uni};
      if (op == lgs_pkg::OP_ASSIGN || op == lgs_pkg::OP_RESAMPLE) token_set[token] = 1'b1;
      if (op == lgs_pkg::OP_CLEAR) n_clear++;
      if (op == lgs_pkg::OP_RESAMPLE) n_resample++;
      pending_beats.push_back(b);
   endtask

   task automatic set_priors(logic [23:0] a, logic [23:0] bt, logic [31:0] s);
      wait_drained();
      write_csr(lgs_pkg::CSR_ALPHA, {8'd0, a});
      write_csr(lgs_pkg::CSR_BETA, {8'd0, bt});
      write_csr(lgs_pkg::CSR_SMOOTH, s);
   endtask

   initial begin
      int tok_pool[$];
      int r;
      logic [15:0] tk;
      clear_counts();
      foreach (token_topic[i]) token_topic[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, each operation, unused code.
      queue_beat(lgs_pkg::OP_ASSIGN, 10'h3FF, 12'hFFF, 16'hFFFF, 4'hF, 32'h0);
      queue_beat(lgs_pkg::OP_ASSIGN, 10'h000, 12'h000, 16'h0000, 4'h0, 32'hFFFF_FFFF);
      queue_beat(lgs_pkg::OP_ASSIGN, 10'h3FF, 12'hFFF, 16'h0001, 4'h7, 32'h0);
      queue_beat(lgs_pkg::OP_RESAMPLE, 10'h3FF, 12'hFFF, 16'hFFFF, 4'h0, 32'h0);
      queue_beat(lgs_pkg::OP_RESAMPLE, 10'h3FF, 12'hFFF, 16'h0001, 4'h0, 32'hFFFF_FFFF);
      queue_beat(lgs_pkg::OP_RESAMPLE, 10'h000, 12'h000, 16'h0000, 4'hF, 32'h8000_0000);
      queue_beat(OP_UNUSED, 10'h155, 12'hAAA, 16'h5555, 4'hA, 32'h1234_5678);
      queue_beat(lgs_pkg::OP_CLEAR, 10'h2AA, 12'h555, 16'hAAAA, 4'h5, 32'hDEAD_BEEF);
      queue_beat(lgs_pkg::OP_RESAMPLE, 10'h000, 12'h000, 16'h0000, 4'h0, 32'h4000_0000);

      // Zero denominator on empty topics: smoothing of zero.
      set_priors(24'hFFFFFF, 24'hFFFFFF, 32'h0);
      queue_beat(lgs_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
      queue_beat(lgs_pkg::OP_RESAMPLE, 10'd3, 12'd9, 16'h0001, 4'h0, 32'h9000_0000);
      queue_beat(lgs_pkg::OP_RESAMPLE, 10'd3, 12'd9, 16'hFFFF, 4'h0, 32'hFFFF_FFFF);

      // All weights zero: beta and alpha zero with empty counts picks the last topic.
      set_priors(24'h0, 24'h0, 32'hFFFF_FFFF);
      queue_beat(lgs_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
      queue_beat(lgs_pkg::OP_RESAMPLE, 10'd1, 12'd2, 16'h0000, 4'h0, 32'h0);
      queue_beat(lgs_pkg::OP_RESAMPLE, 10'd1, 12'd2, 16'h0000, 4'h0, 32'h7FFF_FFFF);

      set_priors(24'd65536, 24'd65536, 32'd65536);
      tok_pool = {16'hFFFF, 16'h0001, 16'h0000};

      // Random part: mostly resamples of assigned tokens over small pools.
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 400 == 399) begin
            case ($urandom_range(3))
               0: set_priors(24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
               1: set_priors(24'h0, 24'h0, 32'h0);
               default: set_priors(24'($urandom), 24'($urandom), $urandom);
            endcase
         end
         r = $urandom_range(99);
         if (r < 2) queue_beat(lgs_pkg::OP_CLEAR, 10'($urandom), 12'($urandom),
                               16'($urandom), 4'($urandom), $urandom);
         else if (r < 4) queue_beat(OP_UNUSED, 10'($urandom), 12'($urandom),
                                    16'($urandom), 4'($urandom), $urandom);
         else if (r < 18 || tok_pool.size() < 4) begin
            tk = (r < 10) ? 16'($urandom) : 16'($urandom_range(255));
            if (!token_set[tk]) tok_pool.push_back(tk);
            queue_beat(lgs_pkg::OP_ASSIGN,
                       (r & 1) ? 10'($urandom) : 10'($urandom_range(7)),
                       (r & 2) ? 12'($urandom) : 12'($urandom_range(15)),
                       tk, 4'($urandom), $urandom);
         end else begin
            tk = 16'(tok_pool[$urandom_range(tok_pool.size() - 1)]);
            queue_beat(lgs_pkg::OP_RESAMPLE,
                       (r < 25) ? 10'($urandom) : 10'($urandom_range(7)),
                       (r < 30) ? 12'($urandom) : 12'($urandom_range(15)),
                       tk, 4'($urandom), $urandom);
         end
         // Keep the queue short so phases and idling track the stimulus.
         while (pending_beats.size() > 8) @(posedge clock);
      end

      wait_drained();
      repeat (700) @(posedge clock);
      $display("covered %0d request beats (%0d resamples, %0d clears), %0d responses",
               sent, n_resample, n_clear, received);
      $display("priors were swept over zero, full-scale and random values");
      if (mismatches == 0 && expected_topics.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("timeout after %0d responses", received);
      $display("simulation failed");
      $finish;
   end

endmodule
